>>> hw/rtl/hhfe_pkg.sv
// Shared types, codes and name tables for the HTTP header field extractor.
package hhfe_pkg;

    // Default accumulator width for the content length
    localparam int LENGTH_BITS_DEF = 32;

    // Byte codes seen in a header block
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Header name lengths
    localparam logic [3:0] HOST_LEN = 4'd4;
    localparam logic [3:0] CLEN_LEN = 4'd14;

    // Leading value spaces that are dropped
    localparam logic [1:0] MAX_SPACES = 2'd2;

    // Matched headers that end parsing
    localparam logic [1:0] MATCH_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        KIND_HOST_BYTE = 2'd0,
        KIND_HOST_END  = 2'd1,
        KIND_DONE      = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REASON_BLANK = 2'd0,
        REASON_TWO   = 2'd1,
        REASON_EOB   = 2'd2
    } reason_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  host_byte;
        logic [31:0] length_value;
        logic        length_seen;
        logic        length_overflow;
        logic        host_seen;
        logic [1:0]  end_reason;
    } result_t;

    // Characters of "Host"
    function automatic logic [7:0] host_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h48; // H
            2'd1: c = 8'h6F; // o
            2'd2: c = 8'h73; // s
            2'd3: c = 8'h74; // t
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Characters of "Content-Length"
    function automatic logic [7:0] clen_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:  c = 8'h43; // C
            4'd1:  c = 8'h6F; // o
            4'd2:  c = 8'h6E; // n
            4'd3:  c = 8'h74; // t
            4'd4:  c = 8'h65; // e
            4'd5:  c = 8'h6E; // n
            4'd6:  c = 8'h74; // t
            4'd7:  c = 8'h2D; // -
            4'd8:  c = 8'h4C; // L
            4'd9:  c = 8'h65; // e
            4'd10: c = 8'h6E; // n
            4'd11: c = 8'h67; // g
            4'd12: c = 8'h74; // t
            4'd13: c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Host value byte or end marker
    function automatic result_t host_result(input kind_t kind, input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = kind;
        r.host_byte = b;
        return r;
    endfunction

    // Summary item
    function automatic result_t summary_result(input logic [31:0] len,
                                               input logic len_seen,
                                               input logic ovf,
                                               input logic host_seen,
                                               input reason_t reason);
        result_t r;
        r = '0;
        r.kind = KIND_DONE;
        r.length_value = len;
        r.length_seen = len_seen;
        r.length_overflow = ovf;
        r.host_seen = host_seen;
        r.end_reason = reason;
        return r;
    endfunction

endpackage

>>> hw/rtl/http_header_field_extractor.sv
// HTTP header field extractor: per-byte header parser with a small result queue.
// A result item is written into the registered result queue when its byte is taken.
// Throughput: one byte per cycle while at most one item is queued; a byte that yields
// two items, or a stalled master side, holds the next byte back until the three-entry
// result queue drains to one item.
// Reset: rst_n clears the parser to the request-line state and empties the queue.
module http_header_field_extractor
    import hhfe_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: data_byte[7:0]; s_axis_tlast: end_of_buffer
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    // m_axis_tdata: host_byte[7:0], length_value[39:8], length_seen[40],
    //   length_overflow[41], host_seen[42], end_reason[44:43], zero pad[47:45]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    // m_axis_tuser: result_kind[1:0]
    output logic [1:0]  m_axis_tuser
);

    typedef enum logic [2:0] {
        PH_REQ   = 3'd0,
        PH_NAME  = 3'd1,
        PH_VALUE = 3'd2,
        PH_SKIP  = 3'd3,
        PH_BLANK = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // Parser state
    phase_t                 phase_reg, phase_next;
    logic [3:0]             pos_reg, pos_next;
    logic [1:0]             cand_reg, cand_next;     // bit0 Host, bit1 Content-Length
    logic [1:0]             mcnt_reg, mcnt_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic                   host_seen_reg, host_seen_next;
    logic                   len_seen_reg, len_seen_next;
    logic                   ovf_reg, ovf_next;
    logic                   cr_reg, cr_next;
    logic                   is_host_reg, is_host_next;
    logic [1:0]             sp_reg, sp_next;

    // Result queue, head at entry 0
    result_t                q_reg [0:2];
    result_t                q_next [0:2];
    logic [1:0]             cnt_reg, cnt_next;

    result_t                res0, res1;
    logic [1:0]             nres;
    logic                   accept, pop;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    // Per-byte parse step
    always_comb
    begin
        logic [7:0]             b;
        logic                   eob;
        logic                   cr;
        logic [LENGTH_BITS+3:0] acc_x10;
        reason_t                reason;

        b   = s_axis_tdata;
        eob = s_axis_tlast;
        cr  = cr_reg;
        acc_x10 = '0;
        reason  = REASON_EOB;

        phase_next     = phase_reg;
        pos_next       = pos_reg;
        cand_next      = cand_reg;
        mcnt_next      = mcnt_reg;
        acc_next       = acc_reg;
        host_seen_next = host_seen_reg;
        len_seen_next  = len_seen_reg;
        ovf_next       = ovf_reg;
        cr_next        = cr_reg;
        is_host_next   = is_host_reg;
        sp_next        = sp_reg;
        res0 = '0;
        res1 = '0;
        nres = 2'd0;

        unique case (phase_reg)
            PH_REQ, PH_SKIP:
            begin
                if (cr && b == CHAR_LF)
                begin
                    phase_next = PH_NAME;
                    pos_next   = 4'd0;
                    cand_next  = 2'b11;
                end
                cr_next = (b == CHAR_CR);
            end
            PH_NAME:
            begin
                if (b == CHAR_CR)
                begin
                    if (pos_reg == 4'd0)
                    begin
                        phase_next = PH_BLANK;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        cr_next    = 1'b1;
                    end
                end
                else if (b == CHAR_COLON)
                begin
                    if (cand_reg[0] && pos_reg == HOST_LEN)
                    begin
                        phase_next   = PH_VALUE;
                        is_host_next = 1'b1;
                        sp_next      = 2'd0;
                    end
                    else if (cand_reg[1] && pos_reg == CLEN_LEN)
                    begin
                        phase_next   = PH_VALUE;
                        is_host_next = 1'b0;
                        ovf_next     = 1'b0;
                        acc_next     = '0;
                        sp_next      = 2'd0;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        cr_next    = 1'b0;
                    end
                end
                else
                begin
                    if (!(pos_reg < HOST_LEN && b == host_char(pos_reg[1:0])))
                        cand_next[0] = 1'b0;
                    if (!(pos_reg < CLEN_LEN && b == clen_char(pos_reg)))
                        cand_next[1] = 1'b0;
                    if (pos_reg != 4'd15)
                        pos_next = pos_reg + 4'd1;
                end
            end
            PH_BLANK:
            begin
                if (b == CHAR_LF)
                begin
                    phase_next = PH_DONE;
                    res0 = summary_result(32'(acc_reg), len_seen_reg, ovf_reg,
                                          host_seen_reg, REASON_BLANK);
                    nres = 2'd1;
                end
                else
                begin
                    phase_next = PH_SKIP;
                    cr_next    = (b == CHAR_CR);
                end
            end
            PH_VALUE:
            begin
                if (b == CHAR_CR)
                begin
                    if (is_host_reg)
                    begin
                        res0 = host_result(KIND_HOST_END, 8'h00);
                        nres = 2'd1;
                        host_seen_next = 1'b1;
                    end
                    else
                    begin
                        len_seen_next = 1'b1;
                    end
                    if (mcnt_reg != MATCH_LIMIT)
                        mcnt_next = mcnt_reg + 2'd1;
                    if (mcnt_next == MATCH_LIMIT)
                    begin
                        phase_next = PH_DONE;
                        if (nres == 2'd0)
                            res0 = summary_result(32'(acc_next), len_seen_next, ovf_next,
                                                  host_seen_next, REASON_TWO);
                        else
                            res1 = summary_result(32'(acc_next), len_seen_next, ovf_next,
                                                  host_seen_next, REASON_TWO);
                        nres = nres + 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        cr_next    = 1'b1;
                    end
                end
                else if (b == CHAR_SPACE && sp_reg < MAX_SPACES)
                begin
                    sp_next = sp_reg + 2'd1;
                end
                else
                begin
                    sp_next = MAX_SPACES;
                    if (is_host_reg)
                    begin
                        res0 = host_result(KIND_HOST_BYTE, b);
                        nres = 2'd1;
                    end
                    else if (b >= CHAR_ZERO && b <= CHAR_NINE)
                    begin
                        // acc * 10 + digit, saturating on carry out of the width
                        acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                                + (LENGTH_BITS+4)'(b[3:0]);
                        if (|acc_x10[LENGTH_BITS+3:LENGTH_BITS])
                        begin
                            acc_next = LEN_MAX;
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_x10[LENGTH_BITS-1:0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // End of buffer closes an open value, reports unless parsing has ended, and restarts the parser
        if (eob)
        begin
            if (phase_next == PH_VALUE)
            begin
                if (is_host_next && nres == 2'd0)
                begin
                    res0 = host_result(KIND_HOST_END, 8'h00);
                    nres = 2'd1;
                end
                if (is_host_next)
                    host_seen_next = 1'b1;
                else
                    len_seen_next = 1'b1;
                if (mcnt_next != MATCH_LIMIT)
                    mcnt_next = mcnt_next + 2'd1;
                if (mcnt_next == MATCH_LIMIT)
                    reason = REASON_TWO;
            end
            if (phase_next != PH_DONE)
            begin
                if (nres == 2'd0)
                    res0 = summary_result(32'(acc_next), len_seen_next, ovf_next,
                                          host_seen_next, reason);
                else
                    res1 = summary_result(32'(acc_next), len_seen_next, ovf_next,
                                          host_seen_next, reason);
                nres = nres + 2'd1;
            end
            phase_next     = PH_REQ;
            pos_next       = 4'd0;
            cand_next      = 2'b11;
            mcnt_next      = 2'd0;
            acc_next       = '0;
            host_seen_next = 1'b0;
            len_seen_next  = 1'b0;
            ovf_next       = 1'b0;
            cr_next        = 1'b0;
            is_host_next   = 1'b0;
            sp_next        = 2'd0;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_REQ;
            pos_reg       <= 4'd0;
            cand_reg      <= 2'b11;
            mcnt_reg      <= 2'd0;
            acc_reg       <= '0;
            host_seen_reg <= 1'b0;
            len_seen_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            cr_reg        <= 1'b0;
            is_host_reg   <= 1'b0;
            sp_reg        <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            cand_reg      <= cand_next;
            mcnt_reg      <= mcnt_next;
            acc_reg       <= acc_next;
            host_seen_reg <= host_seen_next;
            len_seen_reg  <= len_seen_next;
            ovf_reg       <= ovf_next;
            cr_reg        <= cr_next;
            is_host_reg   <= is_host_next;
            sp_reg        <= sp_next;
        end
    end

    // Queue update: pop shifts the head out, new items append behind what remains
    always_comb
    begin
        logic [1:0] base;

        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        q_next[2] = q_reg[2];
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        base = cnt_reg - {1'b0, pop};
        cnt_next = base;
        if (accept)
        begin
            if (nres != 2'd0)
                q_next[base] = res0;
            if (nres == 2'd2)
                q_next[base + 2'd1] = res1;
            cnt_next = base + nres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
        q_reg[2] <= q_next[2];
    end

    // Handshakes and output packing
    assign s_axis_tready = (cnt_reg <= 2'd1);
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tuser  = q_reg[0].kind;
    assign m_axis_tdata  = {3'b000,
                            q_reg[0].end_reason,
                            q_reg[0].host_seen,
                            q_reg[0].length_overflow,
                            q_reg[0].length_seen,
                            q_reg[0].length_value,
                            q_reg[0].host_byte};

endmodule

>>> sim/tb.sv
// Testbench for http_header_field_extractor: request streams checked against a byte-level parser.
module tb
    import hhfe_pkg::*;
();

    localparam int          STALL_LIMIT  = 2000;
    localparam int          RANDOM_BYTES = 1450;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [31:0] LENGTH_MAX   = 32'hFFFF_FFFF;
    localparam logic [8*4-1:0]  HOST_NAME = "Host";
    localparam logic [8*14-1:0] CLEN_NAME = "Content-Length";

    typedef enum logic [2:0] {
        ST_REQUEST,
        ST_NAME,
        ST_VALUE,
        ST_SKIP,
        ST_BLANK,
        ST_DONE
    } parse_state_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Parser shadow state
    parse_state_t pstate;
    int           name_pos;
    logic [1:0]   name_live;     // bit 0: Host, bit 1: Content-Length
    logic [1:0]   match_count;
    logic [31:0]  len_acc;
    logic         host_seen_f;
    logic         len_seen_f;
    logic         ovf_f;
    logic         cr_pending;
    logic         value_is_host;
    logic [1:0]   lead_spaces;
    int           step_results;

    result_t      pending_results[$];
    logic [7:0]   req_q[$];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int bytes_sent     = 0;
    int hold_left      = 0;
    bit no_gaps        = 1'b0;

    http_header_field_extractor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------
    task automatic reset_parser();
        pstate        = ST_REQUEST;
        name_pos      = 0;
        name_live     = 2'b11;
        match_count   = '0;
        len_acc       = '0;
        host_seen_f   = 1'b0;
        len_seen_f    = 1'b0;
        ovf_f         = 1'b0;
        cr_pending    = 1'b0;
        value_is_host = 1'b0;
        lead_spaces   = '0;
    endtask

    function automatic void expect_host(input kind_t k, input logic [7:0] b);
        result_t r;
        r           = '0;
        r.kind      = k;
        r.host_byte = b;
        pending_results.push_back(r);
        step_results++;
    endfunction

    function automatic void expect_summary(input reason_t why);
        result_t r;
        r                 = '0;
        r.kind            = KIND_DONE;
        r.length_value    = len_acc;
        r.length_seen     = len_seen_f;
        r.length_overflow = ovf_f;
        r.host_seen       = host_seen_f;
        r.end_reason      = why;
        pending_results.push_back(r);
        step_results++;
    endfunction

    // A value has ended: count it as a match
    function automatic void close_value();
        if (value_is_host)
            host_seen_f = 1'b1;
        else
            len_seen_f = 1'b1;
        if (match_count < MATCH_LIMIT)
            match_count++;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic       host_ok;
        logic       clen_ok;
        logic [31:0] digit;
        reason_t    why;
        step_results = 0;
        case (pstate)
            ST_REQUEST, ST_SKIP:
            begin
                // wait for CR LF, then a new header line starts
                if (cr_pending && b == CHAR_LF)
                begin
                    pstate    = ST_NAME;
                    name_pos  = 0;
                    name_live = 2'b11;
                end
                cr_pending = (b == CHAR_CR);
            end
            ST_NAME:
            begin
                if (b == CHAR_CR)
                begin
                    if (name_pos == 0)
                        pstate = ST_BLANK;
                    else
                    begin
                        pstate     = ST_SKIP;
                        cr_pending = 1'b1;
                    end
                end
                else if (b == CHAR_COLON)
                begin
                    if (name_live[0] && name_pos == int'(HOST_LEN))
                    begin
                        pstate        = ST_VALUE;
                        value_is_host = 1'b1;
                        lead_spaces   = '0;
                    end
                    else if (name_live[1] && name_pos == int'(CLEN_LEN))
                    begin
                        pstate        = ST_VALUE;
                        value_is_host = 1'b0;
                        ovf_f         = 1'b0;
                        len_acc       = '0;
                        lead_spaces   = '0;
                    end
                    else
                    begin
                        pstate     = ST_SKIP;
                        cr_pending = 1'b0;
                    end
                end
                else
                begin
                    // case-sensitive compare against both names
                    host_ok = 1'b0;
                    clen_ok = 1'b0;
                    if (name_pos < int'(HOST_LEN))
                        host_ok = (b == HOST_NAME[8*(int'(HOST_LEN)-1-name_pos) +: 8]);
                    if (name_pos < int'(CLEN_LEN))
                        clen_ok = (b == CLEN_NAME[8*(int'(CLEN_LEN)-1-name_pos) +: 8]);
                    if (!host_ok)
                        name_live[0] = 1'b0;
                    if (!clen_ok)
                        name_live[1] = 1'b0;
                    if (name_pos < 15)
                        name_pos++;
                end
            end
            ST_BLANK:
            begin
                if (b == CHAR_LF)
                begin
                    pstate = ST_DONE;
                    expect_summary(REASON_BLANK);
                end
                else
                begin
                    pstate     = ST_SKIP;
                    cr_pending = (b == CHAR_CR);
                end
            end
            ST_VALUE:
            begin
                if (b == CHAR_CR)
                begin
                    if (value_is_host)
                        expect_host(KIND_HOST_END, 8'h00);
                    close_value();
                    if (match_count >= MATCH_LIMIT)
                    begin
                        pstate = ST_DONE;
                        expect_summary(REASON_TWO);
                    end
                    else
                    begin
                        pstate     = ST_SKIP;
                        cr_pending = 1'b1;
                    end
                end
                else if (b == CHAR_SPACE && lead_spaces < MAX_SPACES)
                    lead_spaces++;
                else
                begin
                    lead_spaces = MAX_SPACES;
                    if (value_is_host)
                        expect_host(KIND_HOST_BYTE, b);
                    else if (b >= CHAR_ZERO && b <= CHAR_NINE)
                    begin
                        // decimal accumulate, saturating
                        digit = 32'(b - CHAR_ZERO);
                        if (len_acc > (LENGTH_MAX - digit) / 10)
                        begin
                            len_acc = LENGTH_MAX;
                            ovf_f   = 1'b1;
                        end
                        else
                            len_acc = len_acc * 10 + digit;
                    end
                end
            end
            default: ;
        endcase

        // end of buffer closes an open value and reports unless parsing has ended
        if (last)
        begin
            why = REASON_EOB;
            if (pstate == ST_VALUE)
            begin
                if (value_is_host && step_results == 0)
                    expect_host(KIND_HOST_END, 8'h00);
                close_value();
                if (match_count >= MATCH_LIMIT)
                    why = REASON_TWO;
            end
            if (pstate != ST_DONE)
                expect_summary(why);
            reset_parser();
        end
    endtask

    // ---------------------------------------------------------------
    // Sending side
    // ---------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (!no_gaps && $urandom_range(0, 99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        parse_byte(b, last);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Sender pauses until every expected item has come back
    task automatic wait_for_results();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Send the built request, end_of_buffer on its last byte
    task automatic send_request();
        foreach (req_q[i])
            put_byte(req_q[i], i == req_q.size() - 1);
        req_q.delete();
    endtask

    function automatic void add_byte(input logic [7:0] b);
        req_q.push_back(b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_text_byte();
        if ($urandom_range(0, 99) < 90)
            return 8'($urandom_range(8'h21, 8'h7E));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_spaces();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) add_byte(CHAR_SPACE);
    endfunction

    // A header name one edit away from a matched one
    function automatic void add_near_miss();
        string nm;
        int    k;
        int    mode;
        if ($urandom_range(0, 1))
            nm = "Host";
        else
            nm = "Content-Length";
        k    = $urandom_range(0, nm.len() - 1);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < nm.len(); i++)
        begin
            if (i == k && mode == 0)
                add_byte(nm[i] ^ 8'h20);
            else if (!(i == k && mode == 1))
                add_byte(nm[i]);
        end
        if (mode == 2)
            add_byte("s");
        add_text(": v1");
    endfunction

    function automatic void add_random_line();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            add_text("Host:");
            add_spaces();
            n = $urandom_range(0, 10);
            repeat (n) add_byte(rand_text_byte());
        end
        else if (pick < 58)
        begin
            add_text("Content-Length:");
            add_spaces();
            n = $urandom_range(0, 12);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_byte(rand_text_byte());
                else
                    add_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
        end
        else if (pick < 68)
            add_near_miss();
        else if (pick < 76)
        begin
            // name alone, no colon
            if ($urandom_range(0, 1))
                add_text("Host");
            else
                add_text("Content-Length");
        end
        else if (pick < 86)
            add_text("X-Id: 42");
        else if (pick < 93)
        begin
            // lone CR inside the name or the value
            if ($urandom_range(0, 1))
                add_text("Ho\rst:1");
            else
                add_text("Host:a\rb");
        end
        else
            add_text("\rHost:z");
        add_text("\r\n");
    endfunction

    function automatic void build_random_request();
        int pick;
        int n;
        int cut;
        req_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            // raw noise
            n = $urandom_range(1, 40);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(0, 6);
            repeat (n) add_byte(rand_text_byte());
            add_text("\r\n");
            n = $urandom_range(0, 4);
            repeat (n) add_random_line();
            if ($urandom_range(0, 99) < 75)
                add_text("\r\n");
            n = $urandom_range(0, 3);
            repeat (n) add_byte(rand_text_byte());
        end
        // sometimes the buffer ends early
        if ($urandom_range(0, 99) < 20 && req_q.size() > 1)
        begin
            cut = $urandom_range(1, req_q.size());
            while (req_q.size() > cut)
                void'(req_q.pop_back());
        end
    endfunction

    // ---------------------------------------------------------------
    // Receiving side: random stalls plus a counted hold-off
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 32);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each output item with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected item: kind 0x%0h data 0x%0h", m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("host_byte", 32'(want.host_byte), 32'(m_axis_tdata[7:0]));
                check_field("length_value", want.length_value, m_axis_tdata[39:8]);
                check_field("length_seen", 32'(want.length_seen), 32'(m_axis_tdata[40]));
                check_field("length_overflow", 32'(want.length_overflow),
                            32'(m_axis_tdata[41]));
                check_field("host_seen", 32'(want.host_seen), 32'(m_axis_tdata[42]));
                check_field("end_reason", 32'(want.end_reason), 32'(m_axis_tdata[44:43]));
            end
        end
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** http_header_field_extractor: FAILED **");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Host and Content-Length both matched; trailing bytes ignored
    task automatic test_two_headers();
        add_text("G\r\nHost:  a b\r\nContent-Length:1 2\r\nzz");
        send_request();
    endtask

    // Empty Host value, colon-less line, then blank line
    task automatic test_blank_line();
        add_text("\r\nHost:\r\nX\r\n\r\n");
        send_request();
    endtask

    // Largest length without and with saturation
    task automatic test_length_saturation();
        add_text("\r\nContent-Length:4294967295\r\n\r\n");
        send_request();
        add_text("\r\nContent-Length:   4294967296\r\n\r\n");
        send_request();
    endtask

    // Lines that must not match, then a repeated header
    task automatic test_odd_lines();
        add_text("\r\nHost\r\nHo\rst:x\r\n\rHost:y\r\nContent-Length:9\r\nContent-Length:7\r\n");
        send_request();
        add_text("\r\nHost:a\rq\r\nHost:b\r\n");
        send_request();
    endtask

    // Extreme byte values streamed through a Host value
    task automatic test_extreme_bytes();
        add_text("\r\nHost:");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(8'h7F);
        add_text("\r\n\r\n");
        send_request();
    endtask

    // Buffer ending in the request line, in a value, and after a blank line's CR
    task automatic test_buffer_end();
        add_text("x");
        send_request();
        add_text("GE");
        send_request();
        add_text("\r\nHost: ab");
        send_request();
        add_text("\r\nHost: ");
        send_request();
        add_text("\r\nContent-Length:5");
        send_request();
        add_text("\r\nHost:q\r\nContent-Length:42");
        send_request();
        add_text("\r\n\r");
        send_request();
    endtask

    // Receiver holds off while a long Host value streams in
    task automatic test_backpressure();
        wait_for_results();
        hold_left = HOLD_CYCLES;
        add_text("\r\nHost:");
        repeat (40) add_byte(rand_text_byte());
        add_text("\r\n\r\n");
        send_request();
        wait_for_results();
    endtask

    task automatic test_random_requests();
        int first_byte;
        int req_count;
        first_byte = bytes_sent;
        req_count  = 0;
        while (bytes_sent - first_byte < RANDOM_BYTES)
        begin
            req_count++;
            // a stretch with no idling on either side
            no_gaps = (req_count >= 40 && req_count < 70);
            build_random_request();
            send_request();
            if (req_count % 25 == 0)
                wait_for_results();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        reset_parser();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_two_headers();
        test_blank_line();
        test_length_saturation();
        test_odd_lines();
        test_extreme_bytes();
        test_buffer_end();
        test_backpressure();
        test_random_requests();

        // drain and let the pipeline settle
        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** http_header_field_extractor: PASSED **");
        else
            $display("** http_header_field_extractor: FAILED **");
        $finish;
    end

endmodule

>>> http_header_field_extractor.f
hw/rtl/hhfe_pkg.sv
hw/rtl/http_header_field_extractor.sv
sim/tb.sv
